FILE: rtl/core/balance_pid_motor_mixer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the balance PID core and its checker.
// ----------------------------------------------------------------------------
`ifndef BALANCE_PID_MOTOR_MIXER_CORE_ASSERT_SVH
`define BALANCE_PID_MOTOR_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BPM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpm assertion failed");

`endif

FILE: rtl/core/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Field types, fixed-point constants and datapath widths of the balance
// PID core with motor mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpm_pkg;

   // Word field widths
   localparam int PITCH_W    = 16;
   localparam int CMD_W      = 16;
   localparam int KNOB_W     = 12;
   localparam int DRIVE_W    = 19;

   typedef logic signed [PITCH_W-1:0] angle_type;
   typedef logic signed [CMD_W-1:0]   cmd_type;
   typedef logic        [KNOB_W-1:0]  knob_type;
   typedef logic signed [DRIVE_W-1:0] drive_type;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W    = 18;
   localparam int MUL_B_W    = 24;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;

   // Error, gain and integral formats
   localparam int ERR_W      = 17;
   localparam int GAIN_W     = 23;
   localparam int GSUM_W     = 25;
   localparam int INT_FRAC   = 14;

   // Set point scale: 0.314159265 / 1400 in Q.32
   localparam logic signed [MUL_B_W-1:0] SETPOINT_K32 = 24'sd963788;

   // Knob slopes in Q.8
   localparam logic signed [MUL_B_W-1:0] P_SLOPE = 24'sd1510;
   localparam logic signed [MUL_B_W-1:0] I_SLOPE = 24'sd69;
   localparam logic signed [MUL_B_W-1:0] D_SLOPE = 24'sd2010;

   // Gain base values in Q.8
   localparam logic signed [GSUM_W-1:0] P_BASE_Q8 = 25'sd3072000;
   localparam logic signed [GSUM_W-1:0] I_BASE_Q8 = 25'sd128000;
   localparam logic signed [GSUM_W-1:0] D_BASE_Q8 = 25'sd4096000;

   localparam logic [KNOB_W:0] KNOB_CENTRE = 13'd2048;

   // Error saturation limits
   localparam logic signed [ERR_W-1:0] ERR_MAX = 17'sh0FFFF;
   localparam logic signed [ERR_W-1:0] ERR_MIN = 17'sh10000;

   // Drive saturation limits, and the one code never produced
   localparam drive_type DRIVE_MAX  = 19'sh3FFFF;
   localparam drive_type DRIVE_MIN  = 19'sh40001;
   localparam drive_type DRIVE_RAIL = 19'sh40000;

endpackage

`default_nettype wire

FILE: rtl/core/bpm_req_if.sv
// ----------------------------------------------------------------------------
// bpm_req_if
// Sample channel: pitch, remote commands and gain knobs, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bpm_req_if;
   import bpm_pkg::*;

   logic      valid;
   logic      ready;
   angle_type pitch_angle;
   cmd_type   throttle;
   cmd_type   steering;
   knob_type  knob_p;
   knob_type  knob_i;
   knob_type  knob_d;

   modport source (
      output valid, pitch_angle, throttle, steering, knob_p, knob_i, knob_d,
      input  ready
   );

   modport sink (
      input  valid, pitch_angle, throttle, steering, knob_p, knob_i, knob_d,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/bpm_rsp_if.sv
// ----------------------------------------------------------------------------
// bpm_rsp_if
// Result channel: two motor drives and the tilt cutoff flag, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bpm_rsp_if;
   import bpm_pkg::*;

   logic      valid;
   logic      ready;
   drive_type motor_a_drive;
   drive_type motor_b_drive;
   logic      tilt_cutoff;

   modport source (
      output valid, motor_a_drive, motor_b_drive, tilt_cutoff,
      input  ready
   );

   modport sink (
      input  valid, motor_a_drive, motor_b_drive, tilt_cutoff,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/balance_pid_motor_mixer_core.sv
// ----------------------------------------------------------------------------
// balance_pid_motor_mixer_core
// PID balance loop on the pitch angle with integral clamp, knob-set gains,
// steering mix into two saturated motor drives and a tilt cutoff.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake         word
//   -------   ---   ---------------   --------------------------------------
//   req_chan  in    valid/ready       pitch, throttle, steering, 3 knobs
//   rsp_chan  out   valid/ready       motor A drive, motor B drive, cutoff
//
// A word passes from acceptance to a loaded result through ten steps
// of a sequencer that drives one shared 18x24 multiplier and the adders
// around it. The next word is accepted once the result has been loaded,
// so the core never takes a new word before it is through with the last.
// A result waiting in the output register does not block a new word; only
// the final load step waits for the output register to free up.
// Reset is synchronous and clears the sequencer, the integral and the
// stored previous error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module balance_pid_motor_mixer_core #(
   parameter int ANGLE_FRAC_BITS = 14,
   parameter int INTEGRAL_LIMIT  = 1000
) (
   input  logic   clock,
   input  logic   reset,
   bpm_req_if.sink   req_chan,
   bpm_rsp_if.source rsp_chan
);
   import bpm_pkg::*;

   // Derived shifts and widths
   localparam int SP_SHIFT  = 32 - ANGLE_FRAC_BITS;
   localparam int INT_SHIFT = ANGLE_FRAC_BITS + 8 - INT_FRAC;
   localparam int M_SHIFT   = ANGLE_FRAC_BITS + 8;
   localparam longint LIM_Q = longint'(INTEGRAL_LIMIT) * (longint'(1) << INT_FRAC);
   localparam int INT_W     = $clog2(LIM_Q + 1) + 1;
   localparam int ISUM_W    = PROD_W + 1;
   localparam int ERRW_W    = PROD_W + 1;
   localparam int ACC_W     = (((INT_W + INT_SHIFT) > PROD_W) ?
                               (INT_W + INT_SHIFT) : PROD_W) + 2;
   localparam int MIX_W     = ACC_W + 1;
   localparam int CMP_W     = (((ANGLE_FRAC_BITS + 4) > 20) ?
                               (ANGLE_FRAC_BITS + 4) : 20) + 1;

   localparam logic signed [ISUM_W-1:0] LIM_HI  = ISUM_W'(LIM_Q);
   localparam logic signed [ISUM_W-1:0] LIM_LO  = -LIM_HI;
   localparam logic signed [PROD_W-1:0] SP_HALF =
      PROD_W'(longint'(1) << (SP_SHIFT - 1));
   localparam logic signed [PROD_W-1:0] INT_HALF =
      PROD_W'(longint'(1) << (INT_SHIFT - 1));
   localparam logic signed [ACC_W-1:0]  M_BIAS =
      ACC_W'((longint'(1) << M_SHIFT) - 1);
   localparam logic signed [ACC_W-1:0]  ACC_ZERO = '0;
   localparam logic signed [CMP_W-1:0]  THRESH_HI = CMP_W'(longint'(7) << ANGLE_FRAC_BITS);
   localparam logic signed [CMP_W-1:0]  THRESH_LO = -THRESH_HI;

   // Sequencer codes
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SP   = 4'd1;
   localparam logic [3:0] ST_GP   = 4'd2;
   localparam logic [3:0] ST_GI   = 4'd3;
   localparam logic [3:0] ST_GD   = 4'd4;
   localparam logic [3:0] ST_P    = 4'd5;
   localparam logic [3:0] ST_I    = 4'd6;
   localparam logic [3:0] ST_D    = 4'd7;
   localparam logic [3:0] ST_SUM  = 4'd8;
   localparam logic [3:0] ST_MIX  = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   function automatic logic signed [KNOB_W:0] knob_offset(input knob_type k);
      return $signed({1'b0, k} - KNOB_CENTRE);
   endfunction

   // Control state
   logic [3:0]              state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [INT_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0] last_err_ff, last_err_in;

   // Payload registers
   angle_type               pitch_ff, pitch_in;
   cmd_type                 thr_ff, thr_in;
   cmd_type                 steer_ff, steer_in;
   knob_type                knob_p_ff, knob_p_in;
   knob_type                knob_i_ff, knob_i_in;
   knob_type                knob_d_ff, knob_d_in;
   logic                    cut_ff, cut_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [GAIN_W-1:0]       gain_p_ff, gain_p_in;
   logic [GAIN_W-1:0]       gain_i_ff, gain_i_in;
   logic [GAIN_W-1:0]       gain_d_ff, gain_d_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   drive_type               drive_a_ff, drive_a_in;
   drive_type               drive_b_ff, drive_b_in;
   logic                    rsp_cut_ff, rsp_cut_in;

   // Datapath nets
   logic                     req_take;
   logic                     out_load;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [GSUM_W-1:0] base_sel;
   logic signed [GSUM_W-1:0] gain_sum;
   logic [GAIN_W-1:0]        gain_val;
   logic signed [PROD_W-1:0] sp_rnd, sp_val;
   logic signed [ERRW_W-1:0] err_wide;
   logic signed [ERR_W-1:0]  err_sat;
   logic signed [PROD_W-1:0] istep_rnd, istep;
   logic signed [ISUM_W-1:0] isum;
   logic signed [INT_W-1:0]  isum_sat;
   logic signed [ACC_W-1:0]  acc_total;
   logic signed [ACC_W-1:0]  acc_rnd, m_val;
   logic signed [CMP_W-1:0]  ten_pitch;
   logic                     cut_val;
   logic signed [MIX_W-1:0]  sum_a, sum_b, rnd_a, rnd_b, half_a, half_b;
   drive_type                sat_a, sat_b;

   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_load       = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // Select shared multiplier operands and gain base for each step
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      base_sel = P_BASE_Q8;
      case (state_ff)
         ST_SP: begin
            mul_a = MUL_A_W'(thr_ff);
            mul_b = SETPOINT_K32;
         end
         ST_GP: begin
            mul_a = MUL_A_W'(knob_offset(knob_p_ff));
            mul_b = P_SLOPE;
         end
         ST_GI: begin
            mul_a    = MUL_A_W'(knob_offset(knob_i_ff));
            mul_b    = I_SLOPE;
            base_sel = P_BASE_Q8;
         end
         ST_GD: begin
            mul_a    = MUL_A_W'(knob_offset(knob_d_ff));
            mul_b    = D_SLOPE;
            base_sel = I_BASE_Q8;
         end
         ST_P: begin
            mul_a    = MUL_A_W'(err_ff);
            mul_b    = $signed({1'b0, gain_p_ff});
            base_sel = D_BASE_Q8;
         end
         ST_I: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed({1'b0, gain_i_ff});
         end
         ST_D: begin
            mul_a = MUL_A_W'(err_ff) - MUL_A_W'(last_err_ff);
            mul_b = $signed({1'b0, gain_d_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Shared multiplier, product registered every cycle
   assign prod_in = mul_a * mul_b;

   // Gain from knob product: add base, floor at zero
   assign gain_sum = base_sel + $signed(prod_ff[GSUM_W-1:0]);
   assign gain_val = gain_sum[GSUM_W-1] ? '0 : gain_sum[GAIN_W-1:0];

   // Set point with round half up, error saturated to 17 bits
   always_comb begin
      sp_rnd   = prod_ff + SP_HALF;
      sp_val   = sp_rnd >>> SP_SHIFT;
      err_wide = ERRW_W'(pitch_ff) - ERRW_W'(sp_val);
      if (err_wide > ERRW_W'(ERR_MAX)) begin
         err_sat = ERR_MAX;
      end else if (err_wide < ERRW_W'(ERR_MIN)) begin
         err_sat = ERR_MIN;
      end else begin
         err_sat = err_wide[ERR_W-1:0];
      end
   end

   // Integral step rounded to Q.14, accumulate and clamp
   always_comb begin
      istep_rnd = prod_ff + INT_HALF;
      istep     = istep_rnd >>> INT_SHIFT;
      isum      = ISUM_W'(integ_ff) + ISUM_W'(istep);
      if (isum > LIM_HI) begin
         isum_sat = INT_W'(LIM_HI);
      end else if (isum < LIM_LO) begin
         isum_sat = INT_W'(LIM_LO);
      end else begin
         isum_sat = isum[INT_W-1:0];
      end
   end

   // Sum of terms, then truncate toward zero to the integer drive
   always_comb begin
      acc_total = acc_ff + (ACC_W'(integ_ff) <<< INT_SHIFT) + ACC_W'(prod_ff);
      acc_rnd   = acc_ff + (acc_ff[ACC_W-1] ? M_BIAS : ACC_ZERO);
      m_val     = acc_rnd >>> M_SHIFT;
   end

   // Tilt cutoff: compare ten times pitch against seven in Q.F
   always_comb begin
      ten_pitch = (CMP_W'(pitch_ff) <<< 3) + (CMP_W'(pitch_ff) <<< 1);
      cut_val   = (ten_pitch > THRESH_HI) || (ten_pitch < THRESH_LO);
   end

   // Steering mix, halve toward zero, saturate
   always_comb begin
      sum_a  = (MIX_W'(acc_ff) <<< 1) + MIX_W'(steer_ff);
      sum_b  = (MIX_W'(acc_ff) <<< 1) - MIX_W'(steer_ff);
      rnd_a  = sum_a + $signed(MIX_W'(sum_a[MIX_W-1]));
      rnd_b  = sum_b + $signed(MIX_W'(sum_b[MIX_W-1]));
      half_a = rnd_a >>> 1;
      half_b = rnd_b >>> 1;
      if (half_a > MIX_W'(DRIVE_MAX)) begin
         sat_a = DRIVE_MAX;
      end else if (half_a < MIX_W'(DRIVE_MIN)) begin
         sat_a = DRIVE_MIN;
      end else begin
         sat_a = half_a[DRIVE_W-1:0];
      end
      if (half_b > MIX_W'(DRIVE_MAX)) begin
         sat_b = DRIVE_MAX;
      end else if (half_b < MIX_W'(DRIVE_MIN)) begin
         sat_b = DRIVE_MIN;
      end else begin
         sat_b = half_b[DRIVE_W-1:0];
      end
   end

   // Sequencer and per-step register updates
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      integ_in     = integ_ff;
      last_err_in  = last_err_ff;
      pitch_in     = pitch_ff;
      thr_in       = thr_ff;
      steer_in     = steer_ff;
      knob_p_in    = knob_p_ff;
      knob_i_in    = knob_i_ff;
      knob_d_in    = knob_d_ff;
      cut_in       = cut_ff;
      err_in       = err_ff;
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      acc_in       = acc_ff;
      drive_a_in   = drive_a_ff;
      drive_b_in   = drive_b_ff;
      rsp_cut_in   = rsp_cut_ff;

      // drop the shown result once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               pitch_in  = req_chan.pitch_angle;
               thr_in    = req_chan.throttle;
               steer_in  = req_chan.steering;
               knob_p_in = req_chan.knob_p;
               knob_i_in = req_chan.knob_i;
               knob_d_in = req_chan.knob_d;
               state_in  = ST_SP;
            end
         end
         ST_SP: begin
            cut_in   = cut_val;
            state_in = ST_GP;
         end
         ST_GP: begin
            err_in   = err_sat;
            state_in = ST_GI;
         end
         ST_GI: begin
            gain_p_in = gain_val;
            state_in  = ST_GD;
         end
         ST_GD: begin
            gain_i_in = gain_val;
            state_in  = ST_P;
         end
         ST_P: begin
            gain_d_in = gain_val;
            state_in  = ST_I;
         end
         ST_I: begin
            acc_in   = ACC_W'(prod_ff);
            state_in = ST_D;
         end
         ST_D: begin
            integ_in    = isum_sat;
            last_err_in = err_ff;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_total;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            acc_in   = m_val;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold here until the output register frees up
            if (out_load) begin
               drive_a_in   = cut_ff ? '0 : sat_a;
               drive_b_in   = cut_ff ? '0 : sat_b;
               rsp_cut_in   = cut_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_err_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_err_ff  <= last_err_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pitch_ff   <= pitch_in;
      thr_ff     <= thr_in;
      steer_ff   <= steer_in;
      knob_p_ff  <= knob_p_in;
      knob_i_ff  <= knob_i_in;
      knob_d_ff  <= knob_d_in;
      cut_ff     <= cut_in;
      err_ff     <= err_in;
      gain_p_ff  <= gain_p_in;
      gain_i_ff  <= gain_i_in;
      gain_d_ff  <= gain_d_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      drive_a_ff <= drive_a_in;
      drive_b_ff <= drive_b_in;
      rsp_cut_ff <= rsp_cut_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.motor_a_drive = drive_a_ff;
   assign rsp_chan.motor_b_drive = drive_b_ff;
   assign rsp_chan.tilt_cutoff   = rsp_cut_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bpm_checker.sv
// ----------------------------------------------------------------------------
// bpm_checker
// Port-level checks on the balance PID core, bound into the core module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "balance_pid_motor_mixer_core_assert.svh"

module bpm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire bpm_pkg::drive_type rsp_motor_a_drive,
   input wire bpm_pkg::drive_type rsp_motor_b_drive,
   input wire logic               rsp_tilt_cutoff
);
   import bpm_pkg::*;

   // A taken word keeps the core busy in the next cycle
   `BPM_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

   // A fresh result means the sequencer is back to idle
   `BPM_ASSERT_NOW(a_idle_on_result, clock, reset, $rose(rsp_valid), req_ready)

   // Cutoff forces both drives to zero
   `BPM_ASSERT_NOW(a_cut_zero, clock, reset, rsp_valid && rsp_tilt_cutoff, rsp_motor_a_drive == '0 && rsp_motor_b_drive == '0)

   // Saturation never yields the most negative code
   `BPM_ASSERT_NOW(a_drive_range, clock, reset, rsp_valid, rsp_motor_a_drive != DRIVE_RAIL && rsp_motor_b_drive != DRIVE_RAIL)

   // A stalled result word holds
   `BPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_motor_a_drive) && $stable(rsp_motor_b_drive))

endmodule

bind balance_pid_motor_mixer_core bpm_checker u_bpm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_motor_a_drive (rsp_chan.motor_a_drive),
   .rsp_motor_b_drive (rsp_chan.motor_b_drive),
   .rsp_tilt_cutoff   (rsp_chan.tilt_cutoff)
);

`default_nettype wire
